@@ sv/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  // width of the color carried with every pixel
  localparam int ColorW = 8;

  // stepping directions for the major (a) and minor (b) axes
  typedef struct packed {
    logic a_neg;
    logic b_neg;
  } lr_dir_t;

endpackage

`default_nettype wire

@@ sv/lr_if.sv @@
// ----------------------------------------------------------------------------
// lr_req_if / lr_pix_if
// Valid/ready channels for line requests and emitted pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface lr_req_if #(
  parameter int CoordBits = 6
);
  import lr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] start_x;
  logic [CoordBits-1:0] start_y;
  logic [CoordBits-1:0] end_x;
  logic [CoordBits-1:0] end_y;
  logic [ColorW-1:0]    line_color;

  modport source (
    output valid, start_x, start_y, end_x, end_y, line_color,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, end_x, end_y, line_color,
    output ready
  );
endinterface

interface lr_pix_if #(
  parameter int CoordBits = 6
);
  import lr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;
  logic [ColorW-1:0]    pixel_color;
  logic                 last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/lr_step_unit.sv @@
// ----------------------------------------------------------------------------
// lr_step_unit
// Bresenham step: accumulates the error term, decides the minor-axis move,
// steps the major coordinate by one pixel and the minor one only on a move.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_step_unit
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic [COORD_BITS:0]   err_i,
  input  wire logic [COORD_BITS-1:0] da_i,
  input  wire logic [COORD_BITS-1:0] db_i,
  input  wire logic [COORD_BITS-1:0] a_i,
  input  wire logic [COORD_BITS-1:0] b_i,
  input  wire lr_dir_t               dir_i,
  output logic      [COORD_BITS:0]   err_o,
  output logic      [COORD_BITS-1:0] a_o,
  output logic      [COORD_BITS-1:0] b_o
);

  logic [COORD_BITS+1:0] sum;
  logic [COORD_BITS+1:0] lim;
  logic [COORD_BITS+1:0] diff;
  logic                  hit;

  always_comb begin
    sum  = {1'b0, err_i} + {2'b00, db_i} + {{(COORD_BITS+1){1'b0}}, 1'b1};
    lim  = {2'b00, da_i} + {{(COORD_BITS+1){1'b0}}, 1'b1};
    hit  = (sum >= lim);
    diff = sum - lim;
    // err stays below da+1, so it fits one bit above the coordinate width
    err_o = hit ? diff[COORD_BITS:0] : sum[COORD_BITS:0];
    a_o   = dir_i.a_neg ? a_i - 1'b1 : a_i + 1'b1;
    if (hit) begin
      b_o = dir_i.b_neg ? b_i - 1'b1 : b_i + 1'b1;
    end else begin
      b_o = b_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/line_rasterizer_core.sv @@
// After a request is accepted the sequencer enters a setup state; the run
// state that follows registers the first pixel into the output slot.
// In the run state one pixel per cycle comes out of the step unit while the
//   output slot is free. A zero-length line returns to idle, emitting nothing.
// Reset (async, active low) returns the sequencer to idle and drops valid;
//   no state is kept between requests.
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line rasterizer: one request in, one pixel per major-axis step out.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lr_req_if.sink    req_i,
  lr_pix_if.source  pix_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSetup = 2'd1;
  localparam logic [1:0] StRun   = 2'd2;

  logic [1:0] state_q, state_d;

  logic [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic [ColorW-1:0]     color_q;

  logic [COORD_BITS-1:0] a_q, a_d, b_q, b_d;
  logic [COORD_BITS-1:0] da_q, da_d, db_q, db_d;
  logic [COORD_BITS-1:0] rem_q, rem_d;
  logic [COORD_BITS:0]   err_q, err_d;
  logic                  xmaj_q, xmaj_d;
  lr_dir_t               dir_q, dir_d;

  logic                  pix_valid_q, pix_valid_d;
  logic [COORD_BITS-1:0] pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic [ColorW-1:0]     pix_color_q, pix_color_d;
  logic                  pix_last_q, pix_last_d;

  logic [COORD_BITS-1:0] span_x, span_y;
  logic                  x_neg, y_neg;
  logic [COORD_BITS:0]   su_err;
  logic [COORD_BITS-1:0] su_a, su_b;
  logic                  slot_free;
  logic                  req_fire;

  assign req_i.ready = (state_q == StIdle);
  assign req_fire    = req_i.valid && req_i.ready;
  assign slot_free   = !pix_valid_q || pix_o.ready;

  assign pix_o.valid       = pix_valid_q;
  assign pix_o.pixel_x     = pix_x_q;
  assign pix_o.pixel_y     = pix_y_q;
  assign pix_o.pixel_color = pix_color_q;
  assign pix_o.last_pixel  = pix_last_q;

  lr_step_unit #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .err_i (err_q),
    .da_i  (da_q),
    .db_i  (db_q),
    .a_i   (a_q),
    .b_i   (b_q),
    .dir_i (dir_q),
    .err_o (su_err),
    .a_o   (su_a),
    .b_o   (su_b)
  );

  always_comb begin
    x_neg  = (ex_q < sx_q);
    y_neg  = (ey_q < sy_q);
    span_x = x_neg ? sx_q - ex_q : ex_q - sx_q;
    span_y = y_neg ? sy_q - ey_q : ey_q - sy_q;

    state_d     = state_q;
    a_d         = a_q;
    b_d         = b_q;
    da_d        = da_q;
    db_d        = db_q;
    rem_d       = rem_q;
    err_d       = err_q;
    xmaj_d      = xmaj_q;
    dir_d       = dir_q;
    pix_valid_d = pix_valid_q && !pix_o.ready;
    pix_x_d     = pix_x_q;
    pix_y_d     = pix_y_q;
    pix_color_d = pix_color_q;
    pix_last_d  = pix_last_q;

    unique case (state_q)
      StIdle: begin
        if (req_fire) begin
          state_d = StSetup;
        end
      end
      StSetup: begin
        // ties in span step along y
        xmaj_d = (span_x > span_y);
        err_d  = '0;
        if (span_x > span_y) begin
          a_d         = sx_q;
          b_d         = sy_q;
          da_d        = span_x;
          db_d        = span_y;
          dir_d.a_neg = x_neg;
          dir_d.b_neg = y_neg;
        end else begin
          a_d         = sy_q;
          b_d         = sx_q;
          da_d        = span_y;
          db_d        = span_x;
          dir_d.a_neg = y_neg;
          dir_d.b_neg = x_neg;
        end
        rem_d = xmaj_d ? span_x : span_y;
        if (span_x == '0 && span_y == '0) begin
          state_d = StIdle;
        end else begin
          state_d = StRun;
        end
      end
      StRun: begin
        if (slot_free) begin
          pix_valid_d = 1'b1;
          pix_x_d     = xmaj_q ? a_q : b_q;
          pix_y_d     = xmaj_q ? b_q : a_q;
          pix_color_d = color_q;
          pix_last_d  = (rem_q == '0);
          a_d         = su_a;
          b_d         = su_b;
          err_d       = su_err;
          rem_d       = rem_q - 1'b1;
          if (rem_q == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pix_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pix_valid_q <= pix_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      sx_q    <= req_i.start_x;
      sy_q    <= req_i.start_y;
      ex_q    <= req_i.end_x;
      ey_q    <= req_i.end_y;
      color_q <= req_i.line_color;
    end
    a_q         <= a_d;
    b_q         <= b_d;
    da_q        <= da_d;
    db_q        <= db_d;
    rem_q       <= rem_d;
    err_q       <= err_d;
    xmaj_q      <= xmaj_d;
    dir_q       <= dir_d;
    pix_x_q     <= pix_x_d;
    pix_y_q     <= pix_y_d;
    pix_color_q <= pix_color_d;
    pix_last_q  <= pix_last_d;
  end

endmodule

`default_nettype wire

@@ sv/lr_checker.sv @@
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks on the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_checker
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 6
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  req_valid_i,
  input wire logic                  req_ready_i,
  input wire logic                  pix_valid_i,
  input wire logic                  pix_ready_i,
  input wire logic [COORD_BITS-1:0] pix_x_i,
  input wire logic [COORD_BITS-1:0] pix_y_i,
  input wire logic [ColorW-1:0]     pix_color_i,
  input wire logic                  pix_last_i
);

  // stalled pixel holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && !pix_ready_i |=> pix_valid_i && $stable(pix_x_i) &&
      $stable(pix_y_i) && $stable(pix_color_i) && $stable(pix_last_i))
    else $error("stalled pixel changed");

  // one line at a time: busy right after a request transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while setting up a line");

  // no new request while a line still has pixels to send
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i && !pix_last_i |-> !req_ready_i)
    else $error("request ready in the middle of a line");

  // the setup cycle after a request emits no pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i && !pix_valid_i |=> !pix_valid_i)
    else $error("pixel out during line setup");

endmodule

bind line_rasterizer_core lr_checker #(
  .COORD_BITS(COORD_BITS)
) u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .pix_valid_i (pix_o.valid),
  .pix_ready_i (pix_o.ready),
  .pix_x_i     (pix_o.pixel_x),
  .pix_y_i     (pix_o.pixel_y),
  .pix_color_i (pix_o.pixel_color),
  .pix_last_i  (pix_o.last_pixel)
);

`default_nettype wire

@@ tb/sv/lr_pixel_checker.sv @@
// ----------------------------------------------------------------------------
// lr_pixel_checker
// Watches the request and pixel channels of the line rasterizer. It walks
// every accepted line with its own Bresenham stepper and compares each
// accepted pixel, in order, against the oldest pixel still owed.
// ----------------------------------------------------------------------------
module lr_pixel_checker
  import lr_pkg::*;
#(
  parameter int CoordBits = 6
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  lr_req_if          req_i,
  lr_pix_if          pix_i,
  output int unsigned fail_count_o,
  output int unsigned pixels_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [ColorW-1:0]    color;
    logic                 last;
  } pixel_t;

  pixel_t      owed_pixels[$];
  int unsigned fails = 0;
  int unsigned owed  = 0;

  assign fail_count_o  = fails;
  assign pixels_owed_o = owed;

  // Steps along the major axis; the minor axis moves when the accumulator
  // reaches major span + 1. Equal spans step along y.
  function automatic void rasterize_line(input int sx, input int sy, input int ex,
                                         input int ey, input logic [ColorW-1:0] color);
    int     dx, dy, a, a_end, b, b_end, da, db, step_a, step_b, acc, i;
    bit     x_major;
    pixel_t p;
    dx = (ex >= sx) ? ex - sx : sx - ex;
    dy = (ey >= sy) ? ey - sy : sy - ey;
    if (dx == 0 && dy == 0) return;
    x_major = dx > dy;
    if (x_major) begin
      a = sx; a_end = ex; b = sy; b_end = ey; da = dx; db = dy;
    end else begin
      a = sy; a_end = ey; b = sx; b_end = ex; da = dy; db = dx;
    end
    step_a = (a_end > a) ? 1 : -1;
    step_b = (b_end > b) ? 1 : ((b_end < b) ? -1 : 0);
    acc = 0;
    for (i = 0; i <= da; i++) begin
      p.x     = x_major ? a[CoordBits-1:0] : b[CoordBits-1:0];
      p.y     = x_major ? b[CoordBits-1:0] : a[CoordBits-1:0];
      p.color = color;
      p.last  = (i == da);
      owed_pixels.push_back(p);
      acc += db + 1;
      if (acc >= da + 1) begin
        b   += step_b;
        acc -= da + 1;
      end
      a += step_a;
    end
  endfunction

  always @(posedge clk_i) begin
    pixel_t got, want;
    if (rst_ni) begin
      // pixel side first: a line accepted on this edge cannot have a pixel out yet
      if (pix_i.valid && pix_i.ready) begin
        got.x     = pix_i.pixel_x;
        got.y     = pix_i.pixel_y;
        got.color = pix_i.pixel_color;
        got.last  = pix_i.last_pixel;
        if (owed_pixels.size() == 0) begin
          if (fails < ReportLimit)
            $display("%0t: pixel with none owed: x=%0d y=%0d color=%0h last=%0b",
                     $time, got.x, got.y, got.color, got.last);
          fails++;
        end else begin
          want = owed_pixels.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.color !== want.color ||
              got.last !== want.last) begin
            if (fails < ReportLimit)
              $display("%0t: pixel mismatch: want x=%0d y=%0d color=%0h last=%0b, ",
                       $time, want.x, want.y, want.color, want.last,
                       "got x=%0d y=%0d color=%0h last=%0b",
                       got.x, got.y, got.color, got.last);
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        rasterize_line(int'(req_i.start_x), int'(req_i.start_y), int'(req_i.end_x),
                       int'(req_i.end_y), req_i.line_color);
      owed = owed_pixels.size();
    end
  end

endmodule

@@ tb/sv/tb_line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// tb_line_rasterizer_core
// Drives line requests into the rasterizer in bursts with random gaps while
// the pixel side stalls on its own pattern. A directed set covers endpoints
// at the edges, every direction, tied spans and zero-length lines; random
// lines follow. lr_pixel_checker predicts and compares the pixels.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lr_pkg::*;

  localparam int CoordBits  = 6;
  localparam int CoordMax   = (1 << CoordBits) - 1;
  localparam int ColorMax   = (1 << ColorW) - 1;
  localparam int RandLines  = 250;
  localparam int DrainSlack = 10;

  typedef enum int {
    RdyAlways,
    RdyCoin,
    RdyLongStall
  } rdy_mode_e;

  typedef enum int {
    LineAnywhere,
    LineShort,
    LineStraight,
    LineBorder,
    LinePoint
  } line_kind_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pixels_owed;
  int          burst_left = 0;

  lr_req_if #(.CoordBits(CoordBits)) req_if ();
  lr_pix_if #(.CoordBits(CoordBits)) pix_if ();

  line_rasterizer_core #(
    .COORD_BITS(CoordBits)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .pix_o (pix_if)
  );

  lr_pixel_checker #(
    .CoordBits(CoordBits)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .pix_i        (pix_if),
    .fail_count_o (fail_count),
    .pixels_owed_o(pixels_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_line_rasterizer_core: errors");
    $finish;
  end

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : ((v > CoordMax) ? CoordMax : v);
  endfunction

  // Called right after a rising edge; returns right after the edge that
  // accepted the transaction, or after the idle gap that follows it.
  task automatic send_line(input int sx, input int sy, input int ex, input int ey,
                           input int color);
    int gap;
    req_if.valid      <= 1'b1;
    req_if.start_x    <= sx[CoordBits-1:0];
    req_if.start_y    <= sy[CoordBits-1:0];
    req_if.end_x      <= ex[CoordBits-1:0];
    req_if.end_y      <= ey[CoordBits-1:0];
    req_if.line_color <= color[ColorW-1:0];
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Hold off new lines until every owed pixel has come out.
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pixels_owed != 0);
    @(posedge clk_i);
  endtask

  // Pixel-side back-pressure; the mode is redrawn at random when its run ends.
  initial begin : pix_ready_pattern
    rdy_mode_e mode;
    int        mode_left, stall_left;
    pix_if.ready <= 1'b0;
    mode       = RdyAlways;
    mode_left  = 0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode      = rdy_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (stall_left > 0) begin
        stall_left--;
        pix_if.ready <= 1'b0;
      end else begin
        case (mode)
          RdyAlways: begin
            pix_if.ready <= 1'b1;
          end
          RdyCoin: begin
            pix_if.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              stall_left = $urandom_range(1, 12);
              pix_if.ready <= 1'b0;
            end else begin
              pix_if.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  initial begin : stimulus
    line_kind_e kind;
    int         sx, sy, ex, ey, len, n;
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.start_x    <= '0;
    req_if.start_y    <= '0;
    req_if.end_x      <= '0;
    req_if.end_y      <= '0;
    req_if.line_color <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length lines at both corners
    send_line(0, 0, 0, 0, 0);
    send_line(CoordMax, CoordMax, CoordMax, CoordMax, ColorMax);
    // horizontal and vertical, both directions, full span
    send_line(0, 0, CoordMax, 0, ColorMax);
    send_line(CoordMax, 5, 0, 5, 8'h01);
    send_line(7, 0, 7, CoordMax, 8'h80);
    send_line(9, CoordMax, 9, 0, 8'h7F);
    // diagonals: equal spans step along y
    send_line(0, 0, CoordMax, CoordMax, 8'hAA);
    send_line(CoordMax, 0, 0, CoordMax, 8'h55);
    send_line(0, CoordMax, CoordMax, 0, 8'h0F);
    send_line(CoordMax, CoordMax, 0, 0, 8'hF0);
    // two-pixel lines
    send_line(10, 10, 11, 10, 8'h33);
    send_line(10, 10, 10, 11, 8'hCC);
    send_line(10, 10, 11, 11, 8'h3C);
    send_line(11, 11, 10, 10, 8'hC3);
    // shallow and steep extremes
    send_line(0, 0, CoordMax, 1, 8'h12);
    send_line(0, 0, 1, CoordMax, 8'h34);
    send_line(CoordMax, CoordMax - 1, 0, CoordMax, 8'h56);
    send_line(CoordMax - 1, CoordMax, CoordMax, 0, 8'h78);
    // general slopes
    send_line(5, 40, 50, 20, 8'h9A);
    send_line(20, 3, 35, 60, 8'hBC);
    send_line(21, 42, 42, 21, 8'hDE);
    send_line(2, 3, 4, 4, 8'hFE);
    send_line(42, 21, 21, 42, 8'h00);
    wait_drained();

    for (n = 0; n < RandLines; n++) begin
      kind = line_kind_e'($urandom_range(0, 9) < 4 ? LineAnywhere :
                          $urandom_range(0, 4));
      sx = $urandom_range(0, CoordMax);
      sy = $urandom_range(0, CoordMax);
      ex = $urandom_range(0, CoordMax);
      ey = $urandom_range(0, CoordMax);
      case (kind)
        LineShort: begin
          ex = clamp_coord(sx + $urandom_range(0, 16) - 8);
          ey = clamp_coord(sy + $urandom_range(0, 16) - 8);
        end
        LineStraight: begin
          len = $urandom_range(1, CoordMax);
          case ($urandom_range(0, 2))
            0: begin
              ex = clamp_coord($urandom_range(0, 1) ? sx + len : sx - len);
              ey = sy;
            end
            1: begin
              ex = sx;
              ey = clamp_coord($urandom_range(0, 1) ? sy + len : sy - len);
            end
            default: begin
              ex = clamp_coord($urandom_range(0, 1) ? sx + len : sx - len);
              ey = $urandom_range(0, 1) ? sy + (ex - sx) : sy - (ex - sx);
              if (ey < 0 || ey > CoordMax) ey = clamp_coord(ey);
            end
          endcase
        end
        LineBorder: begin
          sx = $urandom_range(0, 1) ? CoordMax : sx;
          sy = $urandom_range(0, 1) ? 0 : sy;
          ex = $urandom_range(0, 1) ? 0 : ex;
          ey = $urandom_range(0, 1) ? CoordMax : ey;
        end
        LinePoint: begin
          if ($urandom_range(0, 1)) begin
            ex = sx;
            ey = sy;
          end
        end
        default: begin
        end
      endcase
      send_line(sx, sy, ex, ey, $urandom_range(0, ColorMax));
      if ($urandom_range(0, 59) == 0) wait_drained();
    end

    req_if.valid <= 1'b0;
    fork
      begin
        do @(negedge clk_i); while (pixels_owed != 0);
      end
    join
    repeat (DrainSlack) @(posedge clk_i);
    if (fail_count == 0 && pixels_owed == 0) begin
      $display("tb_line_rasterizer_core: clean");
    end else begin
      $display("tb_line_rasterizer_core: errors");
    end
    $finish;
  end

endmodule
